### src/mfpm_pkg.sv
package mfpm_pkg;

    // Routed channel count and derived index width
    localparam int ROUTED_CHANNELS = 8;
    localparam int IDX_W           = $clog2(ROUTED_CHANNELS);

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 17;
    localparam int PEAK_W     = 23;
    localparam int CHAN_W     = 3;
    localparam int OCHAN_W    = 6;
    localparam int DEV_W      = 7;
    localparam int COUNT_W    = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;

    // Gain of one in Q1.16, rounding for the Q1.23 x Q1.16 product
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
    localparam int                GAIN_FRAC  = 16;
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);

    // Meter decay: floor(9m / 10) as (9m * ceil(2^30 / 10)) >> 30, exact for 9m < 2^27
    localparam logic [MUL_W-1:0] DECAY_RECIP = 28'd107374183;
    localparam int               DECAY_SHIFT = 30;

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0]  FADE_RESET   = 17'd55;
    localparam logic [COUNT_W-1:0] ROUTED_RESET = 4'd8;
    localparam logic [DEV_W-1:0]   DEV_RESET    = 7'd8;
    localparam logic [DEV_W-1:0]   DEV_MAX      = 7'd64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AUDIO_ENABLE    = 3'd0,
        REG_FADE_INCREMENT  = 3'd1,
        REG_CHANNEL_OFFSET  = 3'd2,
        REG_ROUTED_COUNT    = 3'd3,
        REG_DEVICE_CHANNELS = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SEMIT,
        ST_DMUL,
        ST_DEMIT
    } state_t;

    typedef struct packed {
        logic             in_ready;
        logic             mul_en;
        logic             mul_decay;
        logic             emit_sample;
        logic             emit_report;
        logic             bend;
        logic             report_last;
        logic [IDX_W-1:0] idx;
    } ctrl_t;

endpackage

### src/mfpm_mul.sv
module mfpm_mul
    import mfpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    // Form the signed product of the selected operands
    assign prod_next = a * b;

    // Hold the product for the emit step
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### src/mfpm_ctrl.sv
module mfpm_ctrl
    import mfpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  acc_sample,
    input  logic  acc_bend,
    input  logic  out_free,
    output ctrl_t ctrl
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bend_reg, bend_next;
    logic             idx_last;

    assign idx_last = (idx_reg == IDX_W'(ROUTED_CHANNELS - 1));

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (acc_sample)
                    begin
                        state_next = ST_SMUL;
                    end
                    else if (acc_bend)
                    begin
                        state_next = ST_DMUL;
                    end
                end
            end
            ST_SMUL:
            begin
                state_next = ST_SEMIT;
            end
            ST_SEMIT:
            begin
                if (out_free)
                begin
                    state_next = bend_reg ? ST_DMUL : ST_IDLE;
                end
            end
            ST_DMUL:
            begin
                state_next = ST_DEMIT;
            end
            ST_DEMIT:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? ST_IDLE : ST_DMUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the report index and the block end flag
    always_comb
    begin
        idx_next  = idx_reg;
        bend_next = bend_reg;
        if (state_reg == ST_IDLE && in_valid)
        begin
            idx_next  = '0;
            bend_next = acc_bend;
        end
        else if (state_reg == ST_DEMIT && out_free && !idx_last)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Drive the control group
    always_comb
    begin
        ctrl             = '0;
        ctrl.in_ready    = (state_reg == ST_IDLE);
        ctrl.mul_en      = (state_reg == ST_SMUL) || (state_reg == ST_DMUL);
        ctrl.mul_decay   = (state_reg == ST_DMUL);
        ctrl.emit_sample = (state_reg == ST_SEMIT) && out_free;
        ctrl.emit_report = (state_reg == ST_DEMIT) && out_free;
        ctrl.bend        = bend_reg;
        ctrl.report_last = idx_last;
        ctrl.idx         = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            bend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bend_reg  <= bend_next;
        end
    end

endmodule

### src/monitor_fade_peak_meter.sv
// Monitor output stage: linear gain ramp, output routing and peak meters.
// Input channel (in_valid / in_ready): one routed sample per transfer with its
// channel index, an invalid flag and a block end flag. Channel zero steps the
// monitor gain toward one or zero by fade_increment at the transfer.
// Output channel (out_valid / out_ready): zero to nine results per input; a
// gained sample (result_kind 0) comes first, then on block end one meter
// report per routed channel (result_kind 1). last_result marks the final one.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at once; write
// only while the block is idle.
// Sequencing: every multiply goes through one shared registered multiplier
// under a small sequencer. A sample result is multiplied in ST_SMUL and
// written to the output register from ST_SEMIT; in_ready stays low until the
// sequencer is idle again, so the block takes no new sample before it is
// through with the last. Block end adds ST_DMUL and ST_DEMIT per report.
// An input that causes no result leaves the sequencer idle and in_ready high.
// A stalled receiver holds the output register; the sequencer then waits with
// the next result. Reset clears gain, block peaks, meters and the registers
// to their defaults; the block takes input in the first cycle after reset.
module monitor_fade_peak_meter
    import mfpm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [CHAN_W-1:0]          chan_index,
    input  logic                       sample_invalid,
    input  logic                       block_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_kind,
    output logic [OCHAN_W-1:0]         out_channel,
    output logic signed [SAMPLE_W-1:0] out_value,
    output logic                       was_replaced,
    output logic                       last_result
);

    ctrl_t ctrl;

    logic                       audio_enable_reg;
    logic [GAIN_W-1:0]          fade_increment_reg;
    logic [OCHAN_W-1:0]         channel_offset_reg;
    logic [COUNT_W-1:0]         routed_count_reg;
    logic [DEV_W-1:0]           device_channels_reg;

    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [PEAK_W-1:0]          block_peak_reg [ROUTED_CHANNELS];
    logic [PEAK_W-1:0]          meter_reg      [ROUTED_CHANNELS];

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic                       invalid_reg;
    logic [OCHAN_W-1:0]         ochan_reg;

    logic                       out_valid_reg;
    logic                       kind_reg;
    logic [OCHAN_W-1:0]         ochan_out_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic                       replaced_reg;
    logic                       last_reg;

    logic                       accept;
    logic                       out_free;
    logic [DEV_W-1:0]           dev_lim;
    logic [DEV_W-1:0]           off_lim;
    logic [DEV_W-1:0]           span;
    logic                       acc_sample;

    logic [GAIN_W-1:0]          target;
    logic [GAIN_W:0]            gain_sum;
    logic [GAIN_W-1:0]          gain_diff;

    logic [PEAK_W-1:0]          meter_sel;
    logic [PEAK_W-1:0]          block_sel;
    logic [PEAK_W+3:0]          meter9;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]          rounded;
    logic signed [SAMPLE_W-1:0] gained;
    logic [SAMPLE_W-1:0]        mag_full;
    logic [PEAK_W-1:0]          mag;
    logic [PEAK_W-1:0]          block_chan;
    logic [PEAK_W-1:0]          decayed;
    logic [PEAK_W-1:0]          meter_new;

    assign accept   = in_valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Work out the active channel window
    assign dev_lim    = (device_channels_reg > DEV_MAX) ? DEV_MAX : device_channels_reg;
    assign off_lim    = ({1'b0, channel_offset_reg} < dev_lim) ?
                        {1'b0, channel_offset_reg} : dev_lim;
    assign span       = dev_lim - off_lim;
    assign acc_sample = ({{(DEV_W-CHAN_W){1'b0}}, chan_index} < span)
                        && ({1'b0, chan_index} < routed_count_reg)
                        && (int'(chan_index) < ROUTED_CHANNELS);

    // Step the gain toward its target without passing it
    assign target    = audio_enable_reg ? GAIN_ONE : '0;
    assign gain_sum  = {1'b0, gain_reg} + {1'b0, fade_increment_reg};
    assign gain_diff = gain_reg - target;

    always_comb
    begin
        gain_next = gain_reg;
        if (accept && chan_index == '0)
        begin
            if (gain_reg < target)
            begin
                gain_next = (gain_sum > {1'b0, target}) ? target : gain_sum[GAIN_W-1:0];
            end
            else if (gain_reg > target)
            begin
                gain_next = (gain_diff > fade_increment_reg) ?
                            (gain_reg - fade_increment_reg) : target;
            end
        end
    end

    // Select operands for the shared multiplier
    assign meter_sel = meter_reg[ctrl.idx];
    assign block_sel = block_peak_reg[ctrl.idx];
    assign meter9    = {1'b0, meter_sel, 3'b000} + {4'b0000, meter_sel};
    assign mul_a     = ctrl.mul_decay ? {1'b0, meter9}
                                      : {{(MUL_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign mul_b     = ctrl.mul_decay ? DECAY_RECIP : {{(MUL_W-GAIN_W){1'b0}}, gain_reg};

    mfpm_mul u_mul (
        .clk      (clk),
        .en       (ctrl.mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    mfpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .acc_sample (acc_sample),
        .acc_bend   (block_end),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // Round the gained sample and take its saturated magnitude
    assign rounded    = prod_reg + ROUND_BIAS;
    assign gained     = invalid_reg ? '0 : rounded[GAIN_FRAC +: SAMPLE_W];
    assign mag_full   = gained[SAMPLE_W-1] ? (SAMPLE_W'(0) - gained) : gained;
    assign mag        = mag_full[SAMPLE_W-1] ? {PEAK_W{1'b1}} : mag_full[PEAK_W-1:0];
    assign block_chan = block_peak_reg[chan_reg[IDX_W-1:0]];

    // Decay the meter and merge the block peak
    assign decayed   = prod_reg[DECAY_SHIFT +: PEAK_W];
    assign meter_new = (decayed > block_sel) ? decayed : block_sel;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_enable_reg    <= 1'b0;
            fade_increment_reg  <= FADE_RESET;
            channel_offset_reg  <= '0;
            routed_count_reg    <= ROUTED_RESET;
            device_channels_reg <= DEV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_AUDIO_ENABLE:    audio_enable_reg    <= cfg_wdata[0];
                REG_FADE_INCREMENT:  fade_increment_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_CHANNEL_OFFSET:  channel_offset_reg  <= cfg_wdata[OCHAN_W-1:0];
                REG_ROUTED_COUNT:    routed_count_reg    <= cfg_wdata[COUNT_W-1:0];
                REG_DEVICE_CHANNELS: device_channels_reg <= cfg_wdata[DEV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Hold gain, block peaks and meters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            for (int i = 0; i < ROUTED_CHANNELS; i++)
            begin
                block_peak_reg[i] <= '0;
                meter_reg[i]      <= '0;
            end
        end
        else
        begin
            gain_reg <= gain_next;
            if (ctrl.emit_sample && mag > block_chan)
            begin
                block_peak_reg[chan_reg[IDX_W-1:0]] <= mag;
            end
            if (ctrl.emit_report)
            begin
                meter_reg[ctrl.idx]      <= meter_new;
                block_peak_reg[ctrl.idx] <= '0;
            end
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample_in;
            chan_reg    <= chan_index;
            invalid_reg <= sample_invalid;
            ochan_reg   <= off_lim[OCHAN_W-1:0] + {{(OCHAN_W-CHAN_W){1'b0}}, chan_index};
        end
    end

    // Load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit_sample || ctrl.emit_report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_sample)
        begin
            kind_reg      <= 1'b0;
            ochan_out_reg <= ochan_reg;
            value_reg     <= gained;
            replaced_reg  <= invalid_reg;
            last_reg      <= !ctrl.bend;
        end
        else if (ctrl.emit_report)
        begin
            kind_reg      <= 1'b1;
            ochan_out_reg <= OCHAN_W'(ctrl.idx);
            value_reg     <= {1'b0, meter_new};
            replaced_reg  <= 1'b0;
            last_reg      <= ctrl.report_last;
        end
    end

    assign in_ready     = ctrl.in_ready;
    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign out_channel  = ochan_out_reg;
    assign out_value    = value_reg;
    assign was_replaced = replaced_reg;
    assign last_result  = last_reg;

endmodule

### src/mfpm_checker.sv
module mfpm_checker
    import mfpm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       block_end,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       result_kind,
    input logic [OCHAN_W-1:0]         out_channel,
    input logic signed [SAMPLE_W-1:0] out_value,
    input logic                       was_replaced,
    input logic                       last_result
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(out_channel) && $stable(result_kind) && $stable(last_result))
        else $error("stalled result changed");

    // Block end keeps the block busy with its reports
    a_bend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && block_end |=> !in_ready)
        else $error("ready right after a block end transfer");

    // A replaced sample is a zero sample result
    a_replaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_replaced |-> out_value == '0 && !result_kind)
        else $error("replaced sample not zero");

    // Meter reports are non-negative and never flagged
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> !out_value[SAMPLE_W-1] && !was_replaced)
        else $error("bad meter report");

endmodule

bind monitor_fade_peak_meter mfpm_checker u_mfpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .out_channel  (out_channel),
    .out_value    (out_value),
    .was_replaced (was_replaced),
    .last_result  (last_result)
);

### tb/testbench.sv
module testbench;
    import mfpm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RESET_CYCLES  = 7;
    // longest input: sample result plus eight reports
    localparam int SETTLE_CYCLES = 32;
    localparam int PEAK_CAP      = 8388607;
    localparam int HOLD_CYCLES   = 300;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0]      DATA_ONES  = '1;

    typedef struct {
        logic                       kind;
        logic [OCHAN_W-1:0]         chan;
        logic signed [SAMPLE_W-1:0] value;
        logic                       replaced;
        logic                       last;
    } monitor_out_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_ADDR_W-1:0]      cfg_addr;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          chan_index;
    logic                       sample_invalid;
    logic                       block_end;
    logic                       out_valid;
    logic                       out_ready;
    logic                       result_kind;
    logic [OCHAN_W-1:0]         out_channel;
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       was_replaced;
    logic                       last_result;

    // Shadow of the monitor stage: registers, gain and peak stores
    logic                 m_enable;
    logic [GAIN_W-1:0]    m_fade;
    logic [OCHAN_W-1:0]   m_offset;
    logic [COUNT_W-1:0]   m_routed;
    logic [DEV_W-1:0]     m_dev;
    logic [GAIN_W-1:0]    m_gain;
    logic [PEAK_W-1:0]    m_blk [ROUTED_CHANNELS];
    logic [PEAK_W-1:0]    m_mtr [ROUTED_CHANNELS];

    monitor_out_t monitor_out_q[$];

    int errors         = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int rx_hold_cycles = 0;
    bit tx_gaps_on     = 1'b0;
    bit rx_stall_on    = 1'b0;

    monitor_fade_peak_meter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .chan_index     (chan_index),
        .sample_invalid (sample_invalid),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .out_channel    (out_channel),
        .out_value      (out_value),
        .was_replaced   (was_replaced),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Drive out_ready: random stall bursts, plus one long hold on request
    initial
    begin : rx_drive
        int n;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else if (rx_stall_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(input string name,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare each output transfer with the oldest predicted result
    always @(posedge clk)
    begin : check_results
        monitor_out_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (monitor_out_q.size() == 0)
            begin
                $error("unexpected result: kind %0d channel %0d value %0d",
                       result_kind, out_channel, out_value);
                errors++;
            end
            else
            begin
                want = monitor_out_q.pop_front();
                compare_field("result_kind", want.kind, result_kind);
                compare_field("out_channel", want.chan, out_channel);
                compare_field("out_value", want.value, out_value);
                compare_field("was_replaced", want.replaced, was_replaced);
                compare_field("last_result", want.last, last_result);
            end
        end
    end

    task automatic reset_shadow();
        int i;
        m_enable = 1'b0;
        m_fade   = FADE_RESET;
        m_offset = '0;
        m_routed = ROUTED_RESET;
        m_dev    = DEV_RESET;
        m_gain   = '0;
        for (i = 0; i < ROUTED_CHANNELS; i++)
        begin
            m_blk[i] = '0;
            m_mtr[i] = '0;
        end
    endtask

    // Predict the results of one accepted sample and queue them
    task automatic fade_meter_step(input logic signed [SAMPLE_W-1:0] value,
                                   input logic [CHAN_W-1:0] chan,
                                   input logic invalid,
                                   input logic bend);
        int dev_eff;
        int off;
        int active;
        int target;
        int g;
        int mag;
        int decayed;
        int i;
        longint prod;
        logic signed [SAMPLE_W-1:0] v;
        monitor_out_t r;
        monitor_out_t step_q[$];

        dev_eff = (m_dev > DEV_MAX) ? int'(DEV_MAX) : int'(m_dev);
        off     = (int'(m_offset) < dev_eff) ? int'(m_offset) : dev_eff;
        active  = dev_eff - off;
        if (active > int'(m_routed))
            active = int'(m_routed);
        if (active > ROUTED_CHANNELS)
            active = ROUTED_CHANNELS;

        // Step the gain toward its target at the start of a frame
        if (chan == '0)
        begin
            target = m_enable ? int'(GAIN_ONE) : 0;
            g = int'(m_gain);
            if (g < target)
                g = (g + int'(m_fade) > target) ? target : g + int'(m_fade);
            else if (g > target)
                g = (g - target > int'(m_fade)) ? g - int'(m_fade) : target;
            m_gain = GAIN_W'(g);
        end

        // Gain, route and track the block peak of an active channel
        if (int'(chan) < active)
        begin
            if (invalid)
                v = '0;
            else
            begin
                prod = longint'(value) * longint'(m_gain)
                       + (longint'(1) <<< (GAIN_FRAC - 1));
                v = SAMPLE_W'(prod >>> GAIN_FRAC);
            end
            mag = (v < 0) ? -int'(v) : int'(v);
            if (mag > PEAK_CAP)
                mag = PEAK_CAP;
            if (mag > int'(m_blk[chan]))
                m_blk[chan] = PEAK_W'(mag);
            r = '{KIND_SAMPLE, OCHAN_W'(off + int'(chan)), v, invalid, 1'b0};
            step_q.push_back(r);
        end

        // Decay meters, fold in block peaks and report every channel
        if (bend)
        begin
            for (i = 0; i < ROUTED_CHANNELS; i++)
            begin
                decayed = int'(m_mtr[i]) * 9 / 10;
                m_mtr[i] = (decayed > int'(m_blk[i])) ? PEAK_W'(decayed) : m_blk[i];
                m_blk[i] = '0;
                r = '{KIND_REPORT, OCHAN_W'(i), SAMPLE_W'(m_mtr[i]), 1'b0, 1'b0};
                step_q.push_back(r);
            end
        end

        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k])
            monitor_out_q.push_back(step_q[k]);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (addr)
            REG_AUDIO_ENABLE:    m_enable = data[0];
            REG_FADE_INCREMENT:  m_fade   = data[GAIN_W-1:0];
            REG_CHANNEL_OFFSET:  m_offset = data[OCHAN_W-1:0];
            REG_ROUTED_COUNT:    m_routed = data[COUNT_W-1:0];
            REG_DEVICE_CHANNELS: m_dev    = data[DEV_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample, hold it until the transfer, then predict
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                               input logic [CHAN_W-1:0] chan,
                               input logic invalid,
                               input logic bend);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_in      <= value;
        chan_index     <= chan;
        sample_invalid <= invalid;
        block_end      <= bend;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        fade_meter_step(value, chan, invalid, bend);
        items_sent++;
    endtask

    // Drop valid and wait for every predicted result, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (monitor_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One frame from channel zero upward; the last sample may end the block
    task automatic send_frame(input bit end_block);
        int chans;
        int c;
        chans = (m_routed >= 1 && m_routed <= ROUTED_CHANNELS) ? int'(m_routed)
                                                              : ROUTED_CHANNELS;
        for (c = 0; c < chans; c++)
            send_sample(pick_sample(), CHAN_W'(c), $urandom_range(0, 15) == 0,
                        end_block && c == chans - 1);
    endtask

    // Mostly well-formed frames, some stray samples with random fields
    task automatic random_traffic(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                send_sample(pick_sample(), CHAN_W'($urandom), 1'($urandom),
                            $urandom_range(0, 3) == 0);
            else
                send_frame($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic random_config();
        int off;
        int dev;
        write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
        case ($urandom_range(0, 4))
            0:       write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(1));
            1:       write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(GAIN_ONE));
            2:       write_reg(REG_FADE_INCREMENT, DATA_ONES);
            default: write_reg(REG_FADE_INCREMENT, CFG_DATA_W'($urandom_range(1, 8192)));
        endcase
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16);
        dev = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                           : off + $urandom_range(2, 12);
        write_reg(REG_CHANNEL_OFFSET, CFG_DATA_W'(off));
        write_reg(REG_DEVICE_CHANNELS, CFG_DATA_W'(dev));
        case ($urandom_range(0, 5))
            0:       write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(2));
            1:       write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(4));
            2:       write_reg(REG_ROUTED_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
            default: write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(8));
        endcase
    endtask

    // Registers at reset values and zero gain: all outputs are zero
    task automatic test_defaults();
        int c;
        for (c = 0; c < ROUTED_CHANNELS; c++)
            send_sample(pick_sample(), CHAN_W'(c), 1'b0, c == ROUTED_CHANNELS - 1);
        wait_idle();
    endtask

    // Full gain at once; sample extremes, invalid sample, meter decay
    task automatic test_extremes();
        write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(1));
        write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(GAIN_ONE));
        send_sample(SAMPLE_MAX, CHAN_W'(0), 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, CHAN_W'(1), 1'b0, 1'b0);
        send_sample(pick_sample(), CHAN_W'(2), 1'b1, 1'b0);
        send_sample(SAMPLE_W'(-1), CHAN_W'(3), 1'b0, 1'b0);
        send_sample(SAMPLE_W'(1), CHAN_W'(4), 1'b0, 1'b0);
        send_sample('0, CHAN_W'(5), 1'b0, 1'b0);
        send_sample(pick_sample(), CHAN_W'(6), 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, CHAN_W'(7), 1'b0, 1'b1);
        // second block end lets the large meters decay
        send_sample(SAMPLE_W'(3), CHAN_W'(0), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Zero step holds the gain, unit step ramps down, spare indexes do nothing
    task automatic test_fade_hold();
        int a;
        write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(0));
        write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(0));
        send_sample(SAMPLE_MAX, CHAN_W'(0), 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(1));
        send_sample(SAMPLE_MIN, CHAN_W'(0), 1'b0, 1'b0);
        wait_idle();
        for (a = int'(REG_DEVICE_CHANNELS) + 1; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), DATA_ONES);
        send_sample(SAMPLE_MAX, CHAN_W'(0), 1'b0, 1'b0);
        wait_idle();
    endtask

    // Offset near the top, saturated device count, oversized routed count
    task automatic test_routing_limits();
        write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(1));
        write_reg(REG_CHANNEL_OFFSET, CFG_DATA_W'(60));
        write_reg(REG_DEVICE_CHANNELS, DATA_ONES);
        write_reg(REG_ROUTED_COUNT, DATA_ONES);
        send_sample(SAMPLE_MAX, CHAN_W'(0), 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, CHAN_W'(3), 1'b0, 1'b0);
        send_sample(SAMPLE_MAX, CHAN_W'(4), 1'b0, 1'b0);
        send_sample(SAMPLE_MAX, CHAN_W'(7), 1'b1, 1'b1);
        wait_idle();
        // no device channels: block end gives reports only
        write_reg(REG_DEVICE_CHANNELS, CFG_DATA_W'(0));
        send_sample(SAMPLE_MAX, CHAN_W'(0), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Phases of random traffic, each under a fresh register setting
    task automatic test_config_sweep();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(1));
                write_reg(REG_FADE_INCREMENT, CFG_DATA_W'(1));
                write_reg(REG_CHANNEL_OFFSET, CFG_DATA_W'(63));
                write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(2));
                write_reg(REG_DEVICE_CHANNELS, CFG_DATA_W'(DEV_MAX));
            end
            else if (phase == 1)
            begin
                write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(1));
                write_reg(REG_FADE_INCREMENT, DATA_ONES);
                write_reg(REG_CHANNEL_OFFSET, CFG_DATA_W'(0));
                write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(8));
                write_reg(REG_DEVICE_CHANNELS, CFG_DATA_W'(127));
            end
            else
            begin
                random_config();
            end
            tx_gaps_on  = (phase % 3) != 2;
            rx_stall_on = (phase % 3) != 1;
            random_traffic(55);
            wait_idle();
        end
    endtask

    // Long receiver hold fills the block while the sender keeps offering
    task automatic test_backpressure();
        write_reg(REG_AUDIO_ENABLE, CFG_DATA_W'(1));
        write_reg(REG_CHANNEL_OFFSET, CFG_DATA_W'(0));
        write_reg(REG_DEVICE_CHANNELS, CFG_DATA_W'(8));
        write_reg(REG_ROUTED_COUNT, CFG_DATA_W'(8));
        tx_gaps_on     = 1'b0;
        rx_stall_on    = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        random_traffic(40);
        wait_idle();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_back_to_back();
        random_config();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        random_traffic(60);
        wait_idle();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_addr       <= REG_AUDIO_ENABLE;
        cfg_wdata      <= '0;
        in_valid       <= 1'b0;
        sample_in      <= '0;
        chan_index     <= '0;
        sample_invalid <= 1'b0;
        block_end      <= 1'b0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        test_defaults();
        test_extremes();
        test_fade_hold();
        test_routing_limits();
        test_config_sweep();
        test_backpressure();
        test_back_to_back();

        if (monitor_out_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", monitor_out_q.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
